[design/inverse_normal_cdf_core_defines.svh]
// assertion macros shared by the inverse normal cdf core
// depends on clk and rst_n being visible where a macro is used
`ifndef INVERSE_NORMAL_CDF_CORE_DEFINES_SVH
`define INVERSE_NORMAL_CDF_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define INCDF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define INCDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/incdf_pkg.sv]
// shared constants, types and helpers of the inverse normal cdf core
// no dependencies
package incdf_pkg;

    localparam int PROB_BITS     = 32;
    localparam int OUT_FRAC_BITS = 27;
    localparam int OUT_WIDTH     = OUT_FRAC_BITS + 5;
    localparam int FRAC          = 28;
    localparam int K_W           = 5;
    localparam int X_W           = FRAC + 1;
    localparam int L_W           = 34;
    localparam int LH_W          = 17;
    localparam int P_W           = 46;
    localparam int S_W           = 34;
    localparam int T_W           = 31;
    localparam int SR_W          = T_W + 2;
    localparam int NUM_W         = 32;
    localparam int DEN_W         = 33;
    localparam int RAT_W         = 31;
    localparam int MQ_W          = 36;

    localparam logic [28:0] TWO_LN2_Q = 29'd372130559;
    localparam logic [32:0] C0_Q      = 33'd675253953;
    localparam logic [32:0] C1_Q      = 33'd215514211;
    localparam logic [32:0] C2_Q      = 33'd2772401;
    localparam logic [32:0] D0_Q      = 33'd384611100;
    localparam logic [32:0] D1_Q      = 33'd50806510;
    localparam logic [32:0] D2_Q      = 33'd351114;
    localparam logic [32:0] ONE_Q     = 33'd268435456;

    typedef struct packed {
        logic valid;
        logic invalid;
        logic lower;
    } side_t;

    // position of the top set bit, zero for a zero word
    function automatic logic [K_W-1:0] lead_one(input logic [PROB_BITS-1:0] q);
        logic [K_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < PROB_BITS; i++) begin
            if (q[i]) begin
                pos = K_W'(i);
            end
        end
        return pos;
    endfunction

    // fixed point product, truncated by FRAC bits
    function automatic logic [MQ_W-1:0] qmul(input logic [32:0] a,
                                             input logic [T_W-1:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        return p[FRAC +: MQ_W];
    endfunction

endpackage

[design/incdf_log2_pipe.sv]
// fractional log2 of a normalized mantissa, one result bit per stage
// depends on incdf_pkg
module incdf_log2_pipe
    import incdf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  side_t            in_side,
    input  logic [K_W-1:0]   in_k,
    input  logic [X_W-1:0]   in_x,
    output side_t            out_side,
    output logic [K_W-1:0]   out_k,
    output logic [FRAC-1:0]  out_lg
);

    side_t           side_q [FRAC+1];
    logic [K_W-1:0]  k_q    [FRAC+1];
    logic [X_W-1:0]  y_q    [FRAC+1];
    logic [FRAC-1:0] res_q  [FRAC+1];

    assign side_q[0] = in_side;
    assign k_q[0]    = in_k;
    assign y_q[0]    = in_x;
    assign res_q[0]  = '0;

    for (genvar i = 0; i < FRAC; i++) begin : g_step
        logic [2*X_W-1:0] sq;
        logic [X_W:0]     sq_t;
        logic [X_W-1:0]   y_next;
        logic [FRAC-1:0]  res_next;
        side_t            side_reg;
        logic [K_W-1:0]   k_reg;
        logic [X_W-1:0]   y_reg;
        logic [FRAC-1:0]  res_reg;

        // square, then halve when the value reaches two
        always_comb
        begin
            sq       = (2*X_W)'(y_q[i]) * (2*X_W)'(y_q[i]);
            sq_t     = sq[FRAC+X_W:FRAC];
            res_next = res_q[i];
            if (sq_t[X_W])
            begin
                y_next                 = sq_t[X_W:1];
                res_next[FRAC-1-i]     = 1'b1;
            end
            else
            begin
                y_next = sq_t[X_W-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg <= '0;
            end
            else if (en)
            begin
                side_reg <= side_q[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                k_reg   <= k_q[i];
                y_reg   <= y_next;
                res_reg <= res_next;
            end
        end

        assign side_q[i+1] = side_reg;
        assign k_q[i+1]    = k_reg;
        assign y_q[i+1]    = y_reg;
        assign res_q[i+1]  = res_reg;
    end

    assign out_side = side_q[FRAC];
    assign out_k    = k_q[FRAC];
    assign out_lg   = res_q[FRAC];

endmodule

[design/incdf_div_pipe.sv]
// restoring divider for the rational term, one quotient bit per stage
// depends on incdf_pkg
module incdf_div_pipe
    import incdf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  side_t             in_side,
    input  logic [T_W-1:0]    in_t,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    output side_t             out_side,
    output logic [T_W-1:0]    out_t,
    output logic [RAT_W-1:0]  out_ratio
);

    side_t            side_q [RAT_W+1];
    logic [T_W-1:0]   t_q    [RAT_W+1];
    logic [NUM_W-1:0] num_q  [RAT_W+1];
    logic [DEN_W-1:0] den_q  [RAT_W+1];
    logic [DEN_W-1:0] rem_q  [RAT_W+1];
    logic [RAT_W-1:0] rat_q  [RAT_W+1];

    // dividend is num shifted up by FRAC; its bits above the quotient seed the remainder
    assign side_q[0] = in_side;
    assign t_q[0]    = in_t;
    assign num_q[0]  = in_num;
    assign den_q[0]  = in_den;
    assign rem_q[0]  = DEN_W'(in_num >> (RAT_W - FRAC));
    assign rat_q[0]  = '0;

    for (genvar j = 0; j < RAT_W; j++) begin : g_step
        localparam int BI = RAT_W - 1 - j;
        logic             nbit;
        logic [DEN_W:0]   trial;
        logic [DEN_W-1:0] rem_next;
        logic             qbit;
        side_t            side_reg;
        logic [T_W-1:0]   t_reg;
        logic [NUM_W-1:0] num_reg;
        logic [DEN_W-1:0] den_reg;
        logic [DEN_W-1:0] rem_reg;
        logic [RAT_W-1:0] rat_reg;

        if (BI >= FRAC) begin : g_nb
            assign nbit = num_q[j][BI-FRAC];
        end
        else begin : g_nz
            assign nbit = 1'b0;
        end

        always_comb
        begin
            trial = {rem_q[j], nbit};
            if (trial >= {1'b0, den_q[j]})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_q[j]});
                qbit     = 1'b1;
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                qbit     = 1'b0;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg <= '0;
            end
            else if (en)
            begin
                side_reg <= side_q[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                t_reg   <= t_q[j];
                num_reg <= num_q[j];
                den_reg <= den_q[j];
                rem_reg <= rem_next;
                rat_reg <= {rat_q[j][RAT_W-2:0], qbit};
            end
        end

        assign side_q[j+1] = side_reg;
        assign t_q[j+1]    = t_reg;
        assign num_q[j+1]  = num_reg;
        assign den_q[j+1]  = den_reg;
        assign rem_q[j+1]  = rem_reg;
        assign rat_q[j+1]  = rat_reg;
    end

    assign out_side  = side_q[RAT_W];
    assign out_t     = t_q[RAT_W];
    assign out_ratio = rat_q[RAT_W];

endmodule

[design/inverse_normal_cdf_core.sv]
// top level of the inverse normal cdf core (rational tail approximation)
// depends on incdf_pkg, incdf_log2_pipe, incdf_div_pipe and the defines header
//
// usage:
//   s_* channel takes one probability beat per cycle, unsigned Q0.32 in s_tdata
//   m_* channel returns one beat per probability, in the same order:
//   signed Q4.27 quantile in m_tdata, invalid flag in m_tuser
//   a zero probability raises the flag and returns a zero quantile
//   throughput: one beat per cycle while the output is not stalled;
//   the datapath is a fixed 102 stage pipeline
//     (normalize, 28 log2 squaring steps, scale, 31 sqrt digit steps,
//     4 polynomial steps, 31 divide steps, sign and round)
//   the pipeline advances whenever the output register is empty or being taken,
//   so s_tready follows m_tready and a stall freezes every stage in place
//   bubbles travel as cleared valid bits and never reach m_tvalid
//   reset clears every valid bit; no beat is in flight afterwards
`include "inverse_normal_cdf_core_defines.svh"

module inverse_normal_cdf_core
    import incdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] prob
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] quantile
    output logic [0:0]  m_tuser    // [0] invalid
);

    localparam int DN = FRAC - OUT_FRAC_BITS;

    logic en;

    // stage a: tail selection
    side_t                a_side_reg;
    logic [PROB_BITS-1:0] a_q_reg;
    // stage b: leading one
    side_t                b_side_reg;
    logic [PROB_BITS-1:0] b_q_reg;
    logic [K_W-1:0]       b_k_reg;
    // stage c: mantissa
    side_t                c_side_reg;
    logic [K_W-1:0]       c_k_reg;
    logic [X_W-1:0]       c_x_reg;
    logic [PROB_BITS-1:0] c_shl;
    // log2 outputs
    side_t                lg_side;
    logic [K_W-1:0]       lg_k;
    logic [FRAC-1:0]      lg_val;
    // stage e: -log2 q
    side_t                e_side_reg;
    logic [L_W-1:0]       e_lval_reg;
    logic [K_W:0]         e_kk;
    // stage f: split product by 2 ln 2
    side_t                f_side_reg;
    logic [P_W-1:0]       f_ph_reg;
    logic [P_W-1:0]       f_pl_reg;
    // stage g: rounded -2 ln q
    side_t                g_side_reg;
    logic [S_W-1:0]       g_s_reg;
    logic [63:0]          g_sum;
    // sqrt pipeline taps
    side_t                sq_side [T_W+1];
    logic [S_W-1:0]       sq_s    [T_W+1];
    logic [SR_W-1:0]      sq_rem  [T_W+1];
    logic [T_W-1:0]       sq_root [T_W+1];
    // polynomial stages
    side_t                h1_side_reg, h2_side_reg, h3_side_reg, h4_side_reg;
    logic [T_W-1:0]       h1_t_reg, h2_t_reg, h3_t_reg, h4_t_reg;
    logic [NUM_W-1:0]     h1_n_reg, h2_n_reg, h3_num_reg, h4_num_reg;
    logic [NUM_W-1:0]     h1_e_reg, h2_e_reg;
    logic [DEN_W-1:0]     h3_e_reg, h4_den_reg;
    // divider outputs
    side_t                dv_side;
    logic [T_W-1:0]       dv_t;
    logic [RAT_W-1:0]     dv_ratio;
    // sign stage
    side_t                fm_side_reg;
    logic [T_W-1:0]       fm_mag_reg;
    logic                 fm_neg_reg;
    logic [T_W-1:0]       fm_mag;
    logic                 fm_rneg;
    // output register
    logic                 out_valid_reg;
    logic [OUT_WIDTH-1:0] out_quant_reg;
    logic                 out_inv_reg;
    logic [OUT_WIDTH-1:0] rnd_mag;
    logic [OUT_WIDTH-1:0] quant_next;

    // whole pipeline moves together; it holds only while the output is stuck
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    assign c_shl = PROB_BITS'(b_q_reg << (K_W'(PROB_BITS - 1) - b_k_reg));
    assign e_kk  = (K_W+1)'(PROB_BITS) - (K_W+1)'(lg_k);
    assign g_sum = (64'(f_ph_reg) << LH_W) + 64'(f_pl_reg) + (64'(1) << (FRAC - 1));

    // side band valid bits of the front and back stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_side_reg    <= '0;
            b_side_reg    <= '0;
            c_side_reg    <= '0;
            e_side_reg    <= '0;
            f_side_reg    <= '0;
            g_side_reg    <= '0;
            h1_side_reg   <= '0;
            h2_side_reg   <= '0;
            h3_side_reg   <= '0;
            h4_side_reg   <= '0;
            fm_side_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_side_reg.valid   <= s_tvalid;
            a_side_reg.invalid <= (s_tdata == '0);
            a_side_reg.lower   <= !s_tdata[PROB_BITS-1];
            b_side_reg         <= a_side_reg;
            c_side_reg         <= b_side_reg;
            e_side_reg         <= lg_side;
            f_side_reg         <= e_side_reg;
            g_side_reg         <= f_side_reg;
            h1_side_reg        <= sq_side[T_W];
            h2_side_reg        <= h1_side_reg;
            h3_side_reg        <= h2_side_reg;
            h4_side_reg        <= h3_side_reg;
            fm_side_reg        <= dv_side;
            out_valid_reg      <= fm_side_reg.valid;
        end
    end

    // front datapath: tail value, normalization, log scaling
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // upper half uses 1 - p, which fits since p is at least one half
            a_q_reg    <= s_tdata[PROB_BITS-1] ? (PROB_BITS'(0) - s_tdata) : s_tdata;
            b_q_reg    <= a_q_reg;
            b_k_reg    <= lead_one(a_q_reg);
            c_k_reg    <= b_k_reg;
            c_x_reg    <= c_shl[PROB_BITS-1 -: X_W];
            e_lval_reg <= {e_kk, FRAC'(0)} - L_W'(lg_val);
            f_ph_reg   <= P_W'(e_lval_reg[L_W-1:LH_W]) * P_W'(TWO_LN2_Q);
            f_pl_reg   <= P_W'(e_lval_reg[LH_W-1:0]) * P_W'(TWO_LN2_Q);
            g_s_reg    <= g_sum[FRAC +: S_W];
        end
    end

    incdf_log2_pipe u_log2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_side  (c_side_reg),
        .in_k     (c_k_reg),
        .in_x     (c_x_reg),
        .out_side (lg_side),
        .out_k    (lg_k),
        .out_lg   (lg_val)
    );

    // square root of s shifted up by FRAC, two radicand bits per stage
    assign sq_side[0] = g_side_reg;
    assign sq_s[0]    = g_s_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar j = 0; j < T_W; j++) begin : g_sqrt
        localparam int HI = 2 * T_W - 1 - 2 * j - FRAC;
        logic [1:0]      pair;
        logic [SR_W+1:0] rs;
        logic [SR_W+1:0] trial;
        logic [SR_W-1:0] rem_next;
        logic [T_W-1:0]  root_next;
        side_t           side_reg;
        logic [S_W-1:0]  s_reg;
        logic [SR_W-1:0] rem_reg;
        logic [T_W-1:0]  root_reg;

        // the low FRAC radicand bits are zero
        if (HI >= 1) begin : g_pb
            assign pair = sq_s[j][HI -: 2];
        end
        else begin : g_pz
            assign pair = 2'b00;
        end

        always_comb
        begin
            rs    = {sq_rem[j], pair};
            trial = {2'b00, sq_root[j], 2'b01};
            if (rs >= trial)
            begin
                rem_next  = SR_W'(rs - trial);
                root_next = {sq_root[j][T_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rs[SR_W-1:0];
                root_next = {sq_root[j][T_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg <= '0;
            end
            else if (en)
            begin
                side_reg <= sq_side[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg    <= sq_s[j];
                rem_reg  <= rem_next;
                root_reg <= root_next;
            end
        end

        assign sq_side[j+1] = side_reg;
        assign sq_s[j+1]    = s_reg;
        assign sq_rem[j+1]  = rem_reg;
        assign sq_root[j+1] = root_reg;
    end

    // horner evaluation of numerator and denominator, at most one product per polynomial per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_t_reg   <= sq_root[T_W];
            h1_n_reg   <= NUM_W'(qmul(C2_Q, sq_root[T_W]));
            h1_e_reg   <= NUM_W'(qmul(D2_Q, sq_root[T_W]));
            h2_t_reg   <= h1_t_reg;
            h2_n_reg   <= NUM_W'(qmul(33'(h1_n_reg) + C1_Q, h1_t_reg));
            h2_e_reg   <= NUM_W'(qmul(33'(h1_e_reg) + D1_Q, h1_t_reg));
            h3_t_reg   <= h2_t_reg;
            h3_num_reg <= NUM_W'(33'(h2_n_reg) + C0_Q);
            h3_e_reg   <= DEN_W'(qmul(33'(h2_e_reg) + D0_Q, h2_t_reg));
            h4_t_reg   <= h3_t_reg;
            h4_num_reg <= h3_num_reg;
            h4_den_reg <= h3_e_reg + ONE_Q;
        end
    end

    incdf_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_side   (h4_side_reg),
        .in_t      (h4_t_reg),
        .in_num    (h4_num_reg),
        .in_den    (h4_den_reg),
        .out_side  (dv_side),
        .out_t     (dv_t),
        .out_ratio (dv_ratio)
    );

    // r = t - ratio as sign and magnitude
    always_comb
    begin
        if (dv_t >= dv_ratio)
        begin
            fm_mag  = dv_t - dv_ratio;
            fm_rneg = 1'b0;
        end
        else
        begin
            fm_mag  = dv_ratio - dv_t;
            fm_rneg = 1'b1;
        end
    end

    // drop to the output fraction width, magnitude rounded half up;
    // the magnitude stays far below the saturation limit
    assign rnd_mag    = (OUT_WIDTH'(fm_mag_reg) + (OUT_WIDTH'(1) << (DN - 1))) >> DN;
    assign quant_next = fm_side_reg.invalid ? '0
                      : (fm_neg_reg ? (OUT_WIDTH'(0) - rnd_mag) : rnd_mag);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fm_mag_reg    <= fm_mag;
            fm_neg_reg    <= fm_rneg ^ dv_side.lower;
            out_quant_reg <= quant_next;
            out_inv_reg   <= fm_side_reg.invalid;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_quant_reg;
    assign m_tuser[0] = out_inv_reg;

    `INCDF_ASSERT_NOW(a_inv_zero, m_tvalid && m_tuser[0], m_tdata == '0,
        "invalid beat carries a nonzero quantile")
    `INCDF_ASSERT_NOW(a_out_range, m_tvalid, m_tdata[31] == m_tdata[30],
        "quantile magnitude beyond the reachable range")
    `INCDF_ASSERT_NOW(a_ratio_range, dv_side.valid && !dv_side.invalid,
        dv_ratio[RAT_W-1] == 1'b0, "rational term out of range")
    `INCDF_ASSERT_NEXT(a_zero_flag, s_tvalid && s_tready && s_tdata == '0,
        a_side_reg.valid && a_side_reg.invalid, "zero probability not flagged")

endmodule

[sim/tb.sv]
// testbench of the inverse normal cdf core: drives probabilities, checks quantiles
// depends on incdf_pkg and inverse_normal_cdf_core
module tb
    import incdf_pkg::*;
();

    typedef struct {
        logic [31:0] quantile;
        logic        invalid;
    } quantile_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] prob
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] quantile
    logic [0:0]  m_tuser;   // [0] invalid

    quantile_t expected_q[$];
    int        send_idle_pct;
    int        recv_idle_pct;
    int        n_errors;
    int        n_checked;
    int        n_invalid;

    inverse_normal_cdf_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    // truncated fixed point product
    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> FRAC;
    endfunction

    // bit-serial square root of a 64 bit value
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // quantile predicted for one probability
    function automatic quantile_t predict_quantile(input logic [31:0] p);
        quantile_t  r;
        logic [63:0] q, x, y, lg, lval, s, t, num, den, ratio, mag, lim;
        logic        lower, neg;
        int          k;
        r.quantile = '0;
        r.invalid  = 1'b0;
        if (p == 0)
        begin
            r.invalid = 1'b1;
            return r;
        end
        lower = p < 32'h8000_0000;
        q = lower ? 64'(p) : (64'd1 << 32) - 64'(p);
        k = 0;
        while (k < 63 && (q >> (k + 1)) != 0)
            k++;
        x = (k >= FRAC) ? q >> (k - FRAC) : q << (FRAC - k);
        // log2 of the mantissa, one fraction bit per squaring
        y  = x;
        lg = 0;
        for (int i = 1; i <= FRAC; i++)
        begin
            y = (y * y) >> FRAC;
            if (y >= (64'd2 << FRAC))
            begin
                y  = y >> 1;
                lg = lg | (64'd1 << (FRAC - i));
            end
        end
        lval  = (64'(32 - k) << FRAC) - lg;
        s     = (lval * 64'(TWO_LN2_Q) + (64'd1 << (FRAC - 1))) >> FRAC;
        t     = int_sqrt(s << FRAC);
        num   = fx_mul(fx_mul(64'(C2_Q), t) + 64'(C1_Q), t) + 64'(C0_Q);
        den   = fx_mul(fx_mul(fx_mul(64'(D2_Q), t) + 64'(D1_Q), t) + 64'(D0_Q), t)
                + 64'(ONE_Q);
        ratio = (num << FRAC) / den;
        if (t >= ratio)
        begin
            mag = t - ratio;
            neg = lower;
        end
        else
        begin
            mag = ratio - t;
            neg = !lower;
        end
        // one fraction bit dropped, magnitude rounded half up
        mag = (mag + 1) >> 1;
        lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
        if (mag > lim)
            mag = lim;
        r.quantile = neg ? 32'(64'd0 - mag) : mag[31:0];
        return r;
    endfunction

    // one beat on the slave side, with random idle cycles ahead of it
    task automatic send_prob(input logic [31:0] p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_q.push_back(predict_quantile(p));
        @(negedge clk);
    endtask

    // random ready on the master side
    always @(negedge clk)
        if (rst_n)
            m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin
        quantile_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result quantile=%h invalid=%b",
                         $time, m_tdata, m_tuser[0]);
                n_errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                n_checked++;
                if (e.invalid)
                    n_invalid++;
                if (m_tdata !== e.quantile)
                begin
                    $display("%0t: quantile expected %h actual %h",
                             $time, e.quantile, m_tdata);
                    n_errors++;
                end
                if (m_tuser[0] !== e.invalid)
                begin
                    $display("%0t: invalid expected %b actual %b",
                             $time, e.invalid, m_tuser[0]);
                    n_errors++;
                end
            end
        end
    end

    // extremes, both sides of one half, and the zero probability
    task automatic test_directed();
        logic [31:0] edge_probs[$];
        edge_probs = {32'h0, 32'h1, 32'h2, 32'h3, 32'hffff_ffff, 32'hffff_fffe,
                      32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001, 32'h4000_0000,
                      32'hc000_0000, 32'h0000_ffff, 32'hffff_0000, 32'h1000_0000,
                      32'hf000_0000, 32'haaaa_aaaa, 32'h5555_5555, 32'h0, 32'h1999_999a};
        foreach (edge_probs[i])
            send_prob(edge_probs[i]);
    endtask

    // uniform probabilities plus deep tails of random magnitude and occasional zeros
    task automatic test_random(input int n);
        logic [31:0] p;
        int          sh;
        for (int i = 0; i < n; i++)
        begin
            p = $urandom();
            case ($urandom_range(3))
                0: begin
                    sh = $urandom_range(31);
                    p  = p >> sh;
                end
                1: begin
                    sh = $urandom_range(31);
                    p  = ~(p >> sh);
                end
                default: ;
            endcase
            if ($urandom_range(49) == 0)
                p = '0;
            send_prob(p);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (110) @(posedge clk);
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        n_errors      = 0;
        n_checked     = 0;
        n_invalid     = 0;
        send_idle_pct = 34;
        recv_idle_pct = 58;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(160);
        send_idle_pct = 58;
        recv_idle_pct = 34;
        test_random(160);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(160);
        drain();

        $display("checked %0d quantiles, %0d of them flagged invalid, under three idle mixes",
                 n_checked, n_invalid);
        if (n_errors == 0)
            $display("inverse_normal_cdf_core test passed");
        else
            $display("inverse_normal_cdf_core test failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("timeout");
        $display("inverse_normal_cdf_core test failed");
        $finish;
    end
endmodule
